FILE: src/slot_pool_allocator_top_defines.svh
// Assertion macros shared by the slot pool allocator RTL.
// Each macro expects a clock named clk and an active-high reset named rst in scope.
`ifndef SLOT_POOL_ALLOCATOR_TOP_DEFINES_SVH
`define SLOT_POOL_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SPA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/spa_pkg.sv
`timescale 1ns / 1ps
// Package for the slot pool allocator: sizes, status and command codes,
// beat structs, sequencer states and the free list control struct. No dependencies.
package spa_pkg;

  localparam int MAX_SLOTS = 64;
  localparam int FD_DEPTH  = 1024;

  // Internal widths follow from the pool size.
  localparam int SLOT_W = $clog2(MAX_SLOTS);
  localparam int LINK_W = $clog2(MAX_SLOTS + 1);
  localparam int CNT_W  = LINK_W;

  // Fixed field widths of the command and result beats.
  localparam int STATUS_W   = 2;
  localparam int FD_W       = 10;
  localparam int SLOT_IN_W  = 6;
  localparam int SLOT_OUT_W = 6;
  localparam int POS_W      = 6;
  localparam int ACNT_W     = 7;

  localparam logic [LINK_W-1:0] SLOT_NULL = LINK_W'(MAX_SLOTS);

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK         = 2'd0,
    STAT_FULL       = 2'd1,
    STAT_FD_RANGE   = 2'd2,
    STAT_NOT_IN_USE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic                 cmd;
    logic [FD_W-1:0]      fd;
    logic [SLOT_IN_W-1:0] slot;
  } req_t;

  typedef struct packed {
    status_t               status;
    logic [SLOT_OUT_W-1:0] slot_out;
    logic [POS_W-1:0]      active_pos;
    logic [ACNT_W-1:0]     live_count;
  } rsp_t;

  // Requests from the sequencer to the free list.
  typedef struct packed {
    logic              rd;
    logic              pop;
    logic              push;
    logic [SLOT_W-1:0] slot;
  } fl_ctrl_t;

endpackage

FILE: src/spa_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for every memory of the slot pool allocator.
module spa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/spa_free_list.sv
`timescale 1ns / 1ps
// LIFO free list of slots: head register, link memory and per-entry valid bits.
// Depends on spa_pkg and spa_ram.
module spa_free_list (
  input  logic                         clk,
  input  logic                         rst,
  input  spa_pkg::fl_ctrl_t            ctrl,
  output logic [spa_pkg::LINK_W-1:0]   head,
  output logic                         empty
);

  // A link never written since reset reads as its reset value: the next slot.
  logic [spa_pkg::MAX_SLOTS-1:0] valid;
  logic                          rd_valid;
  logic [spa_pkg::LINK_W-1:0]    rd_dflt;
  logic [spa_pkg::LINK_W-1:0]    ram_q;
  logic [spa_pkg::LINK_W-1:0]    link;
  logic [spa_pkg::SLOT_W-1:0]    head_idx;
  logic                          we;
  logic [spa_pkg::SLOT_W-1:0]    waddr;
  logic [spa_pkg::LINK_W-1:0]    wdata;

  assign head_idx = head[spa_pkg::SLOT_W-1:0];
  assign empty    = (head == spa_pkg::SLOT_NULL);
  assign link     = rd_valid ? ram_q : rd_dflt;

  assign we    = ctrl.pop || ctrl.push;
  assign waddr = ctrl.pop ? head_idx : ctrl.slot;
  assign wdata = ctrl.pop ? spa_pkg::SLOT_NULL : head;

  spa_ram #(
    .WIDTH(spa_pkg::LINK_W),
    .DEPTH(spa_pkg::MAX_SLOTS)
  ) u_link_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (ctrl.rd),
    .raddr(head_idx),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (ctrl.rd) begin
      rd_valid <= valid[head_idx];
      rd_dflt  <= (int'(head_idx) == spa_pkg::MAX_SLOTS - 1) ? spa_pkg::SLOT_NULL
                                                             : head + spa_pkg::LINK_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      valid <= '0;
    end else if (ctrl.pop) begin
      head            <= link;
      valid[head_idx] <= 1'b1;
    end else if (ctrl.push) begin
      head             <= spa_pkg::LINK_W'(ctrl.slot);
      valid[ctrl.slot] <= 1'b1;
    end
  end

endmodule

FILE: src/slot_pool_allocator_top.sv
`timescale 1ns / 1ps
// Top level of the slot pool allocator: command sequencer, active list and
// slot position memories, in-use bits. Depends on spa_pkg, spa_ram, spa_free_list.
//
//   beat      ports              handshake
//   --------  -----------------  ------------------------------------------
//   command   req (spa_pkg::req_t)  taken on a rising edge with start && !busy
//   result    rsp (spa_pkg::rsp_t)  valid for the single cycle done is high
//
// A command passes a check state, which checks it and issues the reads,
// and an execute state, which applies the writes, before its result is
// registered; a rejected command skips the execute state. The registered
// read ports of the link, active list and position memories keep reads
// and writes apart. busy is high from the accepting edge until the result is
// registered; a new command may be taken in the cycle the result is shown.
// Synchronous reset empties the pool at once: no clearing pass is needed,
// since every link carries a valid bit. The receiver cannot stall results.
module slot_pool_allocator_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  spa_pkg::req_t req,
  output logic          done,
  output spa_pkg::rsp_t rsp
);

`include "slot_pool_allocator_top_defines.svh"

  spa_pkg::state_t state, state_next;
  spa_pkg::req_t   req_q;

  logic [spa_pkg::CNT_W-1:0]     count_active, count_next;
  logic [spa_pkg::MAX_SLOTS-1:0] in_use, in_use_next;
  spa_pkg::rsp_t                 rsp_next;
  logic                          done_next;

  spa_pkg::fl_ctrl_t          fl_ctrl;
  logic [spa_pkg::LINK_W-1:0] fl_head;
  logic                       fl_empty;

  // Active list and position memory ports.
  logic                       al_we, al_re, ps_we, ps_re;
  logic [spa_pkg::SLOT_W-1:0] al_waddr, al_wdata, al_raddr, al_q;
  logic [spa_pkg::SLOT_W-1:0] ps_waddr, ps_wdata, ps_raddr, ps_q;

  logic [spa_pkg::SLOT_W-1:0] s_idx;
  logic [spa_pkg::SLOT_W-1:0] head_idx;
  logic [spa_pkg::CNT_W-1:0]  last;
  logic                       fd_oor, slot_oor, chk_err;
  logic                       all_used;

  assign busy     = (state != spa_pkg::S_IDLE);
  assign s_idx    = spa_pkg::SLOT_W'(req_q.slot);
  assign head_idx = fl_head[spa_pkg::SLOT_W-1:0];
  assign last     = count_active - spa_pkg::CNT_W'(1);
  assign fd_oor   = (int'(req_q.fd) >= spa_pkg::FD_DEPTH);
  assign slot_oor = (int'(req_q.slot) >= spa_pkg::MAX_SLOTS);
  assign all_used = (count_active == spa_pkg::CNT_W'(spa_pkg::MAX_SLOTS));

  // A rejected command leaves all state untouched. A full pool is tested
  // before the descriptor range.
  assign chk_err = (req_q.cmd == spa_pkg::CMD_ALLOC)
                 ? (fl_empty || fd_oor)
                 : (slot_oor || !in_use[s_idx] || (count_active == '0));

  spa_free_list u_free_list (
    .clk  (clk),
    .rst  (rst),
    .ctrl (fl_ctrl),
    .head (fl_head),
    .empty(fl_empty)
  );

  spa_ram #(
    .WIDTH(spa_pkg::SLOT_W),
    .DEPTH(spa_pkg::MAX_SLOTS)
  ) u_active_ram (
    .clk  (clk),
    .we   (al_we),
    .waddr(al_waddr),
    .wdata(al_wdata),
    .re   (al_re),
    .raddr(al_raddr),
    .rdata(al_q)
  );

  spa_ram #(
    .WIDTH(spa_pkg::SLOT_W),
    .DEPTH(spa_pkg::MAX_SLOTS)
  ) u_pos_ram (
    .clk  (clk),
    .we   (ps_we),
    .waddr(ps_waddr),
    .wdata(ps_wdata),
    .re   (ps_re),
    .raddr(ps_raddr),
    .rdata(ps_q)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      spa_pkg::S_IDLE: begin
        if (start) begin
          state_next = spa_pkg::S_CHECK;
        end
      end
      spa_pkg::S_CHECK: begin
        state_next = chk_err ? spa_pkg::S_IDLE : spa_pkg::S_EXEC;
      end
      spa_pkg::S_EXEC: begin
        state_next = spa_pkg::S_IDLE;
      end
      default: begin
        state_next = spa_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath controls. The check cycle issues every read the command needs;
  // the execute cycle writes each memory at most once.
  always_comb begin
    fl_ctrl     = '0;
    al_we       = 1'b0;
    al_waddr    = '0;
    al_wdata    = '0;
    al_re       = 1'b0;
    al_raddr    = '0;
    ps_we       = 1'b0;
    ps_waddr    = '0;
    ps_wdata    = '0;
    ps_re       = 1'b0;
    ps_raddr    = '0;
    in_use_next = in_use;
    count_next  = count_active;
    rsp_next    = rsp;
    done_next   = 1'b0;
    unique case (state)
      spa_pkg::S_IDLE: begin
      end
      spa_pkg::S_CHECK: begin
        if (chk_err) begin
          done_next           = 1'b1;
          rsp_next.slot_out   = '0;
          rsp_next.active_pos = '0;
          rsp_next.live_count = spa_pkg::ACNT_W'(count_active);
          if (req_q.cmd == spa_pkg::CMD_RELEASE) begin
            rsp_next.status = spa_pkg::STAT_NOT_IN_USE;
          end else if (fl_empty) begin
            rsp_next.status = spa_pkg::STAT_FULL;
          end else begin
            rsp_next.status = spa_pkg::STAT_FD_RANGE;
          end
        end else if (req_q.cmd == spa_pkg::CMD_ALLOC) begin
          fl_ctrl.rd = 1'b1;
        end else begin
          ps_re    = 1'b1;
          ps_raddr = s_idx;
          al_re    = 1'b1;
          al_raddr = last[spa_pkg::SLOT_W-1:0];
        end
      end
      spa_pkg::S_EXEC: begin
        done_next       = 1'b1;
        rsp_next.status = spa_pkg::STAT_OK;
        if (req_q.cmd == spa_pkg::CMD_ALLOC) begin
          // Pop the head, append it to the active list.
          fl_ctrl.pop           = 1'b1;
          al_we                 = 1'b1;
          al_waddr              = count_active[spa_pkg::SLOT_W-1:0];
          al_wdata              = head_idx;
          ps_we                 = 1'b1;
          ps_waddr              = head_idx;
          ps_wdata              = count_active[spa_pkg::SLOT_W-1:0];
          in_use_next[head_idx] = 1'b1;
          count_next            = count_active + spa_pkg::CNT_W'(1);
          rsp_next.slot_out     = spa_pkg::SLOT_OUT_W'(head_idx);
          rsp_next.active_pos   = spa_pkg::POS_W'(count_active);
          rsp_next.live_count   = spa_pkg::ACNT_W'(count_active + spa_pkg::CNT_W'(1));
        end else begin
          // Move the last active entry into the freed position.
          if (spa_pkg::CNT_W'(ps_q) != last) begin
            al_we    = 1'b1;
            al_waddr = ps_q;
            al_wdata = al_q;
            ps_we    = 1'b1;
            ps_waddr = al_q;
            ps_wdata = ps_q;
          end
          fl_ctrl.push          = 1'b1;
          fl_ctrl.slot          = s_idx;
          in_use_next[s_idx]    = 1'b0;
          count_next            = last;
          rsp_next.slot_out     = spa_pkg::SLOT_OUT_W'(s_idx);
          rsp_next.active_pos   = spa_pkg::POS_W'(ps_q);
          rsp_next.live_count   = spa_pkg::ACNT_W'(last);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= spa_pkg::S_IDLE;
      count_active <= '0;
      in_use       <= '0;
      done         <= 1'b0;
    end else begin
      state        <= state_next;
      count_active <= count_next;
      in_use       <= in_use_next;
      done         <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_q <= req;
    end
    rsp <= rsp_next;
  end

  `SPA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted command did not raise busy")
  `SPA_ASSERT_NEXT(a_exec_done, state == spa_pkg::S_EXEC, done && !busy, "execute gave no result")
  `SPA_ASSERT_NOW(a_done_idle, done, state == spa_pkg::S_IDLE, "result shown while busy")
  `SPA_ASSERT_NOW(a_full_count, 1'b1, fl_empty == all_used, "free list and count disagree")

endmodule
